// ===== rtl/tdc_pkg.sv =====
// shared types and constants for the tolerant double comparator
package tdc_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned UlpsW  = 31;
  localparam logic [UlpsW-1:0] UlpsReset = UlpsW'(4);

  // fixed-point grid of 2^-105 for the absolute test, magnitudes below 4
  localparam int unsigned FixW = 107;
  // biased exponent at which a value sits at 2^-53 (one grid step per lsb)
  localparam logic [10:0] ExpGrid = 11'd970;
  // biased exponent of 4.0; at or above it the absolute test fails and equality is left to the ulp test
  localparam logic [10:0] ExpBig  = 11'd1025;
  localparam logic [10:0] ExpMax  = 11'd2047;
  // 2^-52 plus half an ulp above it, in grid units: 2^53 + 1
  localparam logic [FixW-1:0] TolFix = FixW'(54'h20000000000001);

  typedef struct packed {
    logic [ValueW-1:0] operand_a;
    logic [ValueW-1:0] operand_b;
  } tdc_in_t;

  typedef struct packed {
    logic near_equal;
    logic a_less;
    logic a_greater;
  } tdc_out_t;

endpackage

// ===== rtl/tdc_cmp_unit.sv =====
// compare logic: absolute tolerance, ulp tolerance and ieee ordering
module tdc_cmp_unit import tdc_pkg::*; (
  input  tdc_in_t          op_i,
  input  logic [UlpsW-1:0] max_ulps_i,
  output tdc_out_t         res_o
);

  logic        sa, sb, same_sign;
  logic [62:0] ma, mb, hi_m, lo_m, ulp_dist;
  logic        a_gt_mag;
  logic        a_spec, b_spec, a_nan, b_nan, finite, both_zero;
  logic [10:0] hi_e, lo_e, hi_ex, lo_ex, rs;
  logic [52:0] hi_sig, lo_sig, lo_rsh, lo_mask;
  logic [FixW-1:0] hi_fix, lo_fix, same_lim, diff_lim;
  logic        lo_sticky, tiny, big, hi_le_tol;
  logic        abs_ok, ulp_ok, near, less, greater;

  // field split
  always_comb begin
    sa = op_i.operand_a[63];
    sb = op_i.operand_b[63];
    ma = op_i.operand_a[62:0];
    mb = op_i.operand_b[62:0];
    same_sign = (sa == sb);
    a_spec = (ma[62:52] == ExpMax);
    b_spec = (mb[62:52] == ExpMax);
    a_nan  = a_spec && (ma[51:0] != '0);
    b_nan  = b_spec && (mb[51:0] != '0);
    finite = !a_spec && !b_spec;
    both_zero = (ma == '0) && (mb == '0);
    a_gt_mag = (ma > mb);
    hi_m = a_gt_mag ? ma : mb;
    lo_m = a_gt_mag ? mb : ma;
    ulp_dist = hi_m - lo_m;
  end

  // larger magnitude onto the 2^-105 grid
  always_comb begin
    hi_e   = hi_m[62:52];
    hi_ex  = (hi_e == '0) ? 11'd1 : hi_e;
    hi_sig = {(hi_e != '0), hi_m[51:0]};
    tiny   = (hi_ex < ExpGrid);
    big    = (hi_ex >= ExpBig);
    hi_fix = FixW'(hi_sig) << hi_ex[5:0] - ExpGrid[5:0];
  end

  // smaller magnitude onto the grid, floor plus sticky
  always_comb begin
    lo_e   = lo_m[62:52];
    lo_ex  = (lo_e == '0) ? 11'd1 : lo_e;
    lo_sig = {(lo_e != '0), lo_m[51:0]};
    rs     = ExpGrid - lo_ex;
    lo_mask = ~({53{1'b1}} << rs[5:0]);
    lo_rsh  = lo_sig >> rs[5:0];
    if (lo_ex >= ExpGrid) begin
      lo_fix    = FixW'(lo_sig) << lo_ex[5:0] - ExpGrid[5:0];
      lo_sticky = 1'b0;
    end else if (rs >= 11'd53) begin
      lo_fix    = '0;
      lo_sticky = (lo_sig != '0);
    end else begin
      lo_fix    = FixW'(lo_rsh);
      lo_sticky = ((lo_sig & lo_mask) != '0);
    end
  end

  // absolute test: |a-b| rounds to at most 2^-52
  always_comb begin
    hi_le_tol = (hi_fix <= TolFix);
    same_lim  = hi_fix - TolFix;
    diff_lim  = TolFix - hi_fix;
    if (!finite) begin
      abs_ok = 1'b0;
    end else if (tiny) begin
      abs_ok = 1'b1;
    end else if (big) begin
      abs_ok = 1'b0;
    end else if (same_sign) begin
      abs_ok = hi_le_tol || (lo_fix >= same_lim);
    end else begin
      abs_ok = hi_le_tol &&
               ((lo_fix < diff_lim) || ((lo_fix == diff_lim) && !lo_sticky));
    end
  end

  // ulp test and ieee order
  always_comb begin
    ulp_ok  = same_sign ? (ulp_dist <= 63'(max_ulps_i)) : both_zero;
    near    = abs_ok || ulp_ok;
    less    = 1'b0;
    greater = 1'b0;
    if (!a_nan && !b_nan && !both_zero) begin
      if (!same_sign) begin
        less    = sa;
        greater = sb;
      end else begin
        less    = sa ? (ma > mb) : (ma < mb);
        greater = sa ? (ma < mb) : (ma > mb);
      end
    end
    res_o.near_equal = near;
    res_o.a_less     = !near && less;
    res_o.a_greater  = !near && greater;
  end

endmodule

// ===== rtl/tolerant_double_comparator.sv =====
// top level of the tolerant double comparator
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+--------------------
//  command  | start, busy                  | in_data_i (tdc_in_t)
//  result   | done_o (one-cycle strobe)    | res_o (tdc_out_t)
//  config   | cfg_valid_i, cfg_ready_o     | cfg_data_i
//
// one pair per cycle; a result strobes once its start transfer has passed
// the input register, then the compare logic into the result register
// busy stays low: every start is taken, the receiver cannot stall
// reset sets ulps_q to 4 and drops any pair in flight
module tolerant_double_comparator import tdc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tdc_in_t          in_data_i,
  output logic             done_o,
  output tdc_out_t         res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [UlpsW-1:0] cfg_data_i
);

  logic             vld_q, done_q;
  tdc_in_t          in_q;
  tdc_out_t         res_d, res_q;
  logic [UlpsW-1:0] ulps_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ulps_q <= UlpsReset;
    end else if (cfg_valid_i) begin
      ulps_q <= cfg_data_i;
    end
  end

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= start;
      done_q <= vld_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      in_q <= in_data_i;
    end
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  tdc_cmp_unit u_cmp (
    .op_i       (in_q),
    .max_ulps_i (ulps_q),
    .res_o      (res_d)
  );

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/tdc_checker.sv =====
// port checker for the tolerant double comparator, bound to the top level
module tdc_checker import tdc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input tdc_in_t          in_data_i,
  input logic             done_o,
  input tdc_out_t         res_o,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o,
  input logic [UlpsW-1:0] cfg_data_i
);

  // every transfer is followed by a result strobe
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o) else $error("result strobe missing");

  // no result without a transfer
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start ##1 1'b1 |=> !done_o) else $error("spurious result strobe");

  // near equal excludes any order
  a_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.near_equal) |-> (!res_o.a_less && !res_o.a_greater))
    else $error("order flag on near equal pair");

  // less and greater never together
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.a_less && res_o.a_greater))
    else $error("less and greater both set");

endmodule

bind tolerant_double_comparator tdc_checker u_tdc_checker (.*);
